[hdl/rle_background_unpacker_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the run-length background unpacker
// Shared shorthand for the concurrent checks in the checker module.
// ----------------------------------------------------------------------------
`ifndef RLE_BACKGROUND_UNPACKER_MACROS_SVH
`define RLE_BACKGROUND_UNPACKER_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define RBU_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define RBU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/rbu_pkg.sv]
// ----------------------------------------------------------------------------
// rbu_pkg
// Types and constants shared by the run-length background unpacker modules.
// ----------------------------------------------------------------------------
package rbu_pkg;

    // Configuration port
    localparam int CFG_W      = 17;
    localparam int PADDR_W    = 3;
    localparam int PDATA_W    = 32;
    localparam logic [CFG_W-1:0] FRAME_PIXELS_RESET = 17'd64000;

    // Register index, taken from paddr[2]
    localparam logic REG_FRAME_PIXELS = 1'b0;

    // Stream header codes
    localparam logic [7:0] LITERAL_TOP = 8'd127;
    localparam logic [7:0] NOOP_HEADER = 8'd128;
    localparam logic [8:0] REPEAT_BASE = 9'd257;
    localparam logic [7:0] COLOR_MASK  = 8'h1F;
    localparam logic [7:0] DEPTH_MASK  = 8'h60;
    localparam logic [7:0] WALK_MASK   = 8'h80;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       frame_start;
    } in_item_t;

    typedef struct packed {
        logic [15:0] first_pixel;
        logic [7:0]  run_length;
        logic [4:0]  color;
        logic [1:0]  depth_mask;
        logic        walkable;
        logic        clipped;
    } out_item_t;

    typedef enum logic [1:0] {
        MODE_HEADER  = 2'd0,
        MODE_LITERAL = 2'd1,
        MODE_REPEAT  = 2'd2
    } parse_mode_t;

    // Run request from the parser to the run placer
    typedef struct packed {
        logic       emit;
        logic       clear_index;
        logic [7:0] pixel_byte;
        logic [7:0] len;
    } run_req_t;

endpackage

[hdl/rbu_in_stage.sv]
// ----------------------------------------------------------------------------
// rbu_in_stage
// Input register: captures one stream byte and holds it until it is consumed.
// ----------------------------------------------------------------------------
module rbu_in_stage
    import rbu_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  in_item_t in_data,
    input  logic     consume,
    output logic     item_valid,
    output in_item_t item
);

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;

    assign in_ready   = !valid_reg || consume;
    assign valid_next = (in_valid && in_ready) ? 1'b1 : (consume ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_data;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

[hdl/rbu_parser.sv]
// ----------------------------------------------------------------------------
// rbu_parser
// Header/literal/repeat parser: turns stream bytes into run requests.
// ----------------------------------------------------------------------------
module rbu_parser
    import rbu_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     step,
    input  in_item_t item,
    output run_req_t req
);

    parse_mode_t mode_reg;
    parse_mode_t mode_next;
    logic [6:0]  literal_left_reg;
    logic [6:0]  literal_left_next;
    logic [7:0]  repeat_count_reg;
    logic [7:0]  repeat_count_next;

    parse_mode_t mode_cur;
    logic [6:0]  literal_left_cur;
    logic [7:0]  repeat_count_cur;
    logic [7:0]  b;

    // A frame start clears the parser before the byte is looked at.
    always_comb
    begin
        b = item.data_byte;
        if (item.frame_start)
        begin
            mode_cur         = MODE_HEADER;
            literal_left_cur = 7'd0;
            repeat_count_cur = 8'd0;
        end
        else
        begin
            mode_cur         = mode_reg;
            literal_left_cur = literal_left_reg;
            repeat_count_cur = repeat_count_reg;
        end
    end

    // Next state
    always_comb
    begin
        mode_next         = MODE_HEADER;
        literal_left_next = literal_left_cur;
        repeat_count_next = repeat_count_cur;
        unique case (mode_cur)
            MODE_LITERAL:
            begin
                if (literal_left_cur == 7'd0)
                begin
                    mode_next = MODE_HEADER;
                end
                else
                begin
                    mode_next         = MODE_LITERAL;
                    literal_left_next = literal_left_cur - 7'd1;
                end
            end
            MODE_REPEAT:
            begin
                mode_next = MODE_HEADER;
            end
            default:
            begin
                if (b <= LITERAL_TOP)
                begin
                    mode_next         = MODE_LITERAL;
                    literal_left_next = b[6:0];
                end
                else if (b != NOOP_HEADER)
                begin
                    mode_next         = MODE_REPEAT;
                    repeat_count_next = 8'(REPEAT_BASE - {1'b0, b});
                end
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        req.clear_index = item.frame_start;
        req.pixel_byte  = b;
        req.emit        = 1'b0;
        req.len         = 8'd1;
        unique case (mode_cur)
            MODE_LITERAL:
            begin
                req.emit = 1'b1;
                req.len  = 8'd1;
            end
            MODE_REPEAT:
            begin
                req.emit = 1'b1;
                req.len  = repeat_count_cur;
            end
            default:
            begin
                req.emit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg         <= MODE_HEADER;
            literal_left_reg <= 7'd0;
            repeat_count_reg <= 8'd0;
        end
        else if (step)
        begin
            mode_reg         <= mode_next;
            literal_left_reg <= literal_left_next;
            repeat_count_reg <= repeat_count_next;
        end
    end

endmodule

[hdl/rbu_run_place.sv]
// ----------------------------------------------------------------------------
// rbu_run_place
// Pixel index tracking and clipping of runs at the frame limit.
// ----------------------------------------------------------------------------
module rbu_run_place
    import rbu_pkg::*;
#(
    parameter int MAX_PIXELS = 65536
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  run_req_t         req,
    input  logic [CFG_W-1:0] frame_pixels,
    output logic             emit,
    output out_item_t        result
);

    localparam int IDX_W = $clog2(MAX_PIXELS + 1);
    localparam logic [IDX_W-1:0] MAX_IDX = IDX_W'(MAX_PIXELS);

    logic [IDX_W-1:0] index_reg;
    logic [IDX_W-1:0] index_next;
    logic [IDX_W-1:0] limit;
    logic [IDX_W-1:0] avail;
    logic [IDX_W:0]   run_end;
    logic [IDX_W-1:0] len_ext;
    logic             clip;

    always_comb
    begin
        limit    = (frame_pixels > CFG_W'(MAX_PIXELS)) ? MAX_IDX : IDX_W'(frame_pixels);
        len_ext  = IDX_W'(req.len);
        run_end  = {1'b0, index_reg} + {1'b0, len_ext};
        avail    = limit - index_reg;
        clip     = len_ext > avail;

        // Saturate the index at the largest frame.
        if (run_end > (IDX_W+1)'(MAX_PIXELS))
        begin
            index_next = MAX_IDX;
        end
        else
        begin
            index_next = run_end[IDX_W-1:0];
        end

        // Drop runs that start at or past the limit.
        emit               = req.emit && (index_reg < limit);
        result.first_pixel = 16'(index_reg);
        result.run_length  = clip ? 8'(avail) : req.len;
        result.color       = 5'(req.pixel_byte & COLOR_MASK);
        result.depth_mask  = 2'((req.pixel_byte & DEPTH_MASK) >> 5);
        result.walkable    = 1'((req.pixel_byte & WALK_MASK) >> 7);
        result.clipped     = clip;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            index_reg <= '0;
        end
        else if (step)
        begin
            if (req.clear_index)
            begin
                index_reg <= '0;
            end
            else if (req.emit)
            begin
                index_reg <= index_next;
            end
        end
    end

endmodule

[hdl/rle_background_unpacker.sv]
// ----------------------------------------------------------------------------
// rle_background_unpacker
// PackBits-style background decoder that emits one run item per decoded run inside the frame.
// ----------------------------------------------------------------------------
// Usage:
//   Feed the compressed image one byte per transfer on in_valid/in_ready.
//   Set frame_start on the first byte of each image; it clears the parser and
//   the pixel index before that byte is parsed as a header.
//   Each literal byte gives a run of length one; a repeat header plus its byte
//   gives one run of the full length. Header and no-op bytes give no run.
//   Runs reaching past frame_pixels are shortened and flagged clipped; runs
//   starting at or past it are dropped while parsing goes on.
//   Results leave on out_valid/out_ready, one transfer per run.
// Pipeline and throughput:
//   A run passes from its byte transfer through the input register, then the
//   parser and run placer, into the output register.
//   One byte per cycle is sustained while out_ready stays high; the parser
//   state update and the pixel index update are the loops.
// Stalls and reset:
//   When out_ready is low the output register holds its run and the input
//   register fills; in_ready drops only when both are full.
//   rst_n clears both registers, the parser and the pixel index, and loads
//   frame_pixels with 64000. Write frame_pixels over APB only while idle.
// ----------------------------------------------------------------------------
module rle_background_unpacker
    import rbu_pkg::*;
#(
    parameter int MAX_PIXELS = 65536
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  in_item_t           in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output out_item_t          out_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    logic             item_valid;
    in_item_t         item;
    logic             step;
    run_req_t         req;
    logic             emit;
    out_item_t        result;

    logic             out_valid_reg;
    logic             out_valid_next;
    out_item_t        out_data_reg;
    logic [CFG_W-1:0] frame_pixels_reg;
    logic [CFG_W-1:0] frame_pixels_next;
    logic             reg_write;

    // ------------------------------------------------------------------
    // Configuration port: single register, zero wait states
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign reg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        frame_pixels_next = frame_pixels_reg;
        prdata            = '0;
        unique case (paddr[2])
            REG_FRAME_PIXELS:
            begin
                prdata = PDATA_W'(frame_pixels_reg);
                if (reg_write)
                begin
                    frame_pixels_next = pwdata[CFG_W-1:0];
                end
            end
            default:
            begin
                prdata = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_pixels_reg <= FRAME_PIXELS_RESET;
        end
        else
        begin
            frame_pixels_reg <= frame_pixels_next;
        end
    end

    // ------------------------------------------------------------------
    // Input register
    // ------------------------------------------------------------------
    // Advance the byte through the parser whenever the output slot is free
    // or is being emptied in this cycle.
    assign step = item_valid && (!out_valid_reg || out_ready);

    rbu_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .consume    (step),
        .item_valid (item_valid),
        .item       (item)
    );

    // ------------------------------------------------------------------
    // Parser and run placement
    // ------------------------------------------------------------------
    rbu_parser u_parser (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .item  (item),
        .req   (req)
    );

    rbu_run_place #(
        .MAX_PIXELS (MAX_PIXELS)
    ) u_run_place (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (step),
        .req          (req),
        .frame_pixels (frame_pixels_reg),
        .emit         (emit),
        .result       (result)
    );

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    // Load on a step (valid only if a run was produced), drop after a
    // transfer, hold otherwise.
    always_comb
    begin
        if (step)
        begin
            out_valid_next = emit;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && emit)
        begin
            out_data_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

[hdl/rbu_checker.sv]
// ----------------------------------------------------------------------------
// rbu_props
// Port-level checks for the run-length background unpacker, bound to the top.
// ----------------------------------------------------------------------------
`include "rle_background_unpacker_macros.svh"

module rbu_props
    import rbu_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  in_item_t           in_data,
    input  logic               out_valid,
    input  logic               out_ready,
    input  out_item_t          out_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    input  logic [PDATA_W-1:0] prdata,
    input  logic               pready
);

    logic               cfg_write;
    logic [PDATA_W-1:0] cfg_value;
    logic [16:0]        run_end;
    logic               len_ok;

    assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == REG_FRAME_PIXELS);
    assign cfg_value = PDATA_W'(pwdata[CFG_W-1:0]);
    assign run_end   = 17'(out_data.first_pixel) + 17'(out_data.run_length);
    assign len_ok    = (out_data.run_length != 8'd0) && (out_data.run_length <= 8'd128);

    // Hold a waiting byte.
    `RBU_ASSERT_NEXT(a_in_hold, in_valid && !in_ready, in_valid && $stable(in_data), "waiting byte changed")

    // Hold a stalled run.
    `RBU_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "stalled run changed")

    // Run length stays within one PackBits run.
    `RBU_ASSERT_SAME(a_len_range, out_valid, len_ok, "run length out of range")

    // Clipping keeps every run inside the largest frame.
    `RBU_ASSERT_SAME(a_run_end, out_valid, run_end <= 17'd65536, "run ends past frame")

    // A frame_pixels write reads back on the next cycle.
    `RBU_ASSERT_NEXT(a_cfg_readback, cfg_write, prdata == $past(cfg_value), "frame_pixels readback mismatch")

endmodule

bind rle_background_unpacker rbu_props u_rbu_props (.*);
